>>> rtl/assert_macros.svh
// assertion helpers for the rtl, used by tpdu_parse
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define TPC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: property failed");
// condition must never be seen at a clock edge out of reset
`define TPC_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define TPC_ASSERT(lbl, clk, rstn, prop)
`define TPC_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> rtl/tpdu_pkg.sv
package tpdu_pkg;

    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 17;
    localparam int TOTAL_W = IDX_W + 1;
    localparam int PLEN_W  = 16;
    localparam int CNT_W   = 7;
    localparam int WORD_W  = 32;
    localparam int ACT_W   = 4;
    localparam int OUT_TDATA_W = 72;

    localparam logic [BYTE_W-1:0] HDR_LEN      = 8'd4;
    localparam logic [BYTE_W-1:0] ACT_MASK     = 8'h0f;
    localparam logic [BYTE_W-1:0] SUB_LEN_MIN  = 8'd2;
    localparam logic [BYTE_W-1:0] SUB_TYPE_MAX = 8'd1;
    localparam logic [PLEN_W-1:0] REQ_BODY_LEN = 16'd24;
    localparam logic [PLEN_W-1:0] RSP_BODY_LEN = 16'd4;
    localparam logic [IDX_W-1:0]  IDX_MAX      = 17'h1ffff;

    // header byte positions
    localparam logic [IDX_W-1:0] POS_ACTION = 17'd0;
    localparam logic [IDX_W-1:0] POS_PLEN_LO = 17'd1;
    localparam logic [IDX_W-1:0] POS_PLEN_HI = 17'd2;
    localparam logic [IDX_W-1:0] POS_HLEN   = 17'd3;

    // action codes
    localparam logic [ACT_W-1:0] ACT_CREATE_REQ = 4'd0;
    localparam logic [ACT_W-1:0] ACT_CREATE_RSP = 4'd1;
    localparam logic [ACT_W-1:0] ACT_DATA       = 4'd2;

    typedef struct packed {
        logic [WORD_W-1:0] first_word;
        logic              body_ok;
        logic [CNT_W-1:0]  sub_hdr_cnt;
        logic [7:0]        hdr_len;
        logic [PLEN_W-1:0] pay_len;
        logic [ACT_W-1:0]  action;
        logic              status;
    } t_result;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [BYTE_W-1:0] data;
    } t_item;

endpackage

>>> rtl/tpdu_in_stage.sv
module tpdu_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [tpdu_pkg::BYTE_W-1:0] i_data,
    input  logic                       i_last,
    output logic                       o_ready,
    input  logic                       i_advance,
    output tpdu_pkg::t_item            o_item
);
    import tpdu_pkg::*;

    logic              r_valid;
    logic              r_last;
    logic [BYTE_W-1:0] r_data;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
            r_last <= i_last;
        end
    end

    assign o_item = '{valid: r_valid, last: r_last, data: r_data};

endmodule

>>> rtl/tpdu_parse.sv
`include "assert_macros.svh"

module tpdu_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  tpdu_pkg::t_item    i_item,
    output logic               o_res_valid,
    output tpdu_pkg::t_result  o_res
);
    import tpdu_pkg::*;

    logic [IDX_W-1:0]  r_idx,      n_idx;
    logic [ACT_W-1:0]  r_action,   n_action;
    logic              r_flags_nz, n_flags_nz;
    logic [PLEN_W-1:0] r_plen,     n_plen;
    logic [7:0]        r_hlen,     n_hlen;
    logic [7:0]        r_next_sub, n_next_sub;
    logic [CNT_W-1:0]  r_sub_cnt,  n_sub_cnt;
    logic              r_sub_err,  n_sub_err;
    logic [WORD_W-1:0] r_word,     n_word;
    logic              r_rsvd_nz,  n_rsvd_nz;
    logic              r_type_due, n_type_due;

    logic [BYTE_W-1:0]  w_b;
    logic [BYTE_W-1:0]  w_masked;
    logic [7:0]         w_rem;
    logic [IDX_W-1:0]   w_off;
    logic [TOTAL_W-1:0] w_total;
    logic [TOTAL_W-1:0] w_hlen_ext;
    logic               w_bad;
    logic               w_body;

    assign w_b        = i_item.data;
    assign w_masked   = w_b & ACT_MASK;
    assign w_rem      = r_hlen - r_idx[7:0];
    assign w_off      = r_idx - {{(IDX_W-8){1'b0}}, r_hlen};

    always_comb begin
        n_idx      = r_idx;
        n_action   = r_action;
        n_flags_nz = r_flags_nz;
        n_plen     = r_plen;
        n_hlen     = r_hlen;
        n_next_sub = r_next_sub;
        n_sub_cnt  = r_sub_cnt;
        n_sub_err  = r_sub_err;
        n_word     = r_word;
        n_rsvd_nz  = r_rsvd_nz;
        n_type_due = r_type_due;

        if (r_idx == POS_ACTION) begin
            n_action   = w_masked[ACT_W-1:0];
            n_flags_nz = w_b[7:4] != 4'd0;
        end else if (r_idx == POS_PLEN_LO) begin
            n_plen = {r_plen[15:8], w_b};
        end else if (r_idx == POS_PLEN_HI) begin
            n_plen = {w_b, r_plen[7:0]};
        end else if (r_idx == POS_HLEN) begin
            n_hlen = w_b;
        end else if (r_idx < {{(IDX_W-8){1'b0}}, r_hlen}) begin
            // subheader chain walk
            if (!r_sub_err) begin
                if (r_type_due) begin
                    n_type_due = 1'b0;
                    if (w_b > SUB_TYPE_MAX) begin
                        n_sub_err = 1'b1;
                    end else begin
                        n_sub_cnt = r_sub_cnt + 7'd1;
                    end
                end else if (r_idx[7:0] == r_next_sub) begin
                    if (w_b < SUB_LEN_MIN || w_b > w_rem) begin
                        n_sub_err = 1'b1;
                    end else begin
                        n_next_sub = r_idx[7:0] + w_b;
                        n_type_due = 1'b1;
                    end
                end
            end
        end else if (r_hlen >= HDR_LEN) begin
            if (w_off[IDX_W-1:2] == '0) begin
                n_word = r_word | ({24'd0, w_b} << {w_off[1:0], 3'b000});
            end else if (w_off[IDX_W-1:3] == '0 && w_b != 8'd0) begin
                n_rsvd_nz = 1'b1;
            end
        end

        if (r_idx != IDX_MAX) begin
            n_idx = r_idx + 17'd1;
        end
    end

    // end of pdu checks on the updated state
    always_comb begin
        w_total    = {1'b0, r_idx} + 18'd1;
        w_hlen_ext = {{(TOTAL_W-8){1'b0}}, n_hlen};
        w_bad = (w_total < {{(TOTAL_W-8){1'b0}}, HDR_LEN})
              || (n_action > ACT_DATA) || n_flags_nz
              || (n_hlen < HDR_LEN) || (w_hlen_ext > w_total)
              || ({2'b00, n_plen} != (w_total - w_hlen_ext)) || n_sub_err;
        w_body = 1'b0;
        if (!w_bad) begin
            if (n_action == ACT_CREATE_REQ) begin
                w_body = n_hlen == HDR_LEN && n_plen == REQ_BODY_LEN && !n_rsvd_nz;
            end else if (n_action == ACT_CREATE_RSP) begin
                w_body = n_hlen == HDR_LEN && n_plen == RSP_BODY_LEN;
            end else begin
                w_body = 1'b1;
            end
        end
        o_res.status      = w_bad;
        o_res.action      = n_action;
        o_res.pay_len     = n_plen;
        o_res.hdr_len     = n_hlen;
        o_res.sub_hdr_cnt = n_sub_cnt;
        o_res.body_ok     = w_body;
        o_res.first_word  = (n_hlen >= HDR_LEN
                             && w_total >= w_hlen_ext + 18'd4) ? n_word : '0;
    end

    assign o_res_valid = i_step && i_item.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last)) begin
            r_idx      <= '0;
            r_action   <= '0;
            r_flags_nz <= 1'b0;
            r_plen     <= '0;
            r_hlen     <= '0;
            r_next_sub <= HDR_LEN;
            r_sub_cnt  <= '0;
            r_sub_err  <= 1'b0;
            r_word     <= '0;
            r_rsvd_nz  <= 1'b0;
            r_type_due <= 1'b0;
        end else if (i_step) begin
            r_idx      <= n_idx;
            r_action   <= n_action;
            r_flags_nz <= n_flags_nz;
            r_plen     <= n_plen;
            r_hlen     <= n_hlen;
            r_next_sub <= n_next_sub;
            r_sub_cnt  <= n_sub_cnt;
            r_sub_err  <= n_sub_err;
            r_word     <= n_word;
            r_rsvd_nz  <= n_rsvd_nz;
            r_type_due <= n_type_due;
        end
    end

    // a subheader never ends before the fixed header
    `TPC_ASSERT(a_next_sub_floor, i_clk, i_rst_n, r_next_sub >= HDR_LEN)
    // a broken chain never waits for a type byte
    `TPC_NEVER(a_type_after_err, i_clk, i_rst_n, r_type_due && r_sub_err)
    // the byte counter restarts after each final item
    `TPC_ASSERT(a_idx_restart, i_clk, i_rst_n, i_step && i_item.last |=> r_idx == '0)
    // no result without an item being processed
    `TPC_ASSERT(a_res_needs_step, i_clk, i_rst_n, o_res_valid |-> i_item.valid)

endmodule

>>> rtl/tpdu_out_stage.sv
module tpdu_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tpdu_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free,
    output tpdu_pkg::t_result o_res
);
    import tpdu_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> rtl/tunnel_pdu_header_checker_unit.sv
// tunnel pdu header checker
// input channel s_axis: one pdu byte per item in tdata, tlast on the final byte
// of each pdu. output channel m_axis: one result item per pdu, sent after its
// final byte, carrying the well-formed status, the header fields as read, the
// count of good subheaders, the body check and the first payload word.
// path: a final byte goes into the input register, then its result into the
// result register, from which it is offered on m_axis
// throughput: one byte per cycle while the result register can take a final
// byte; bytes other than the final one never wait on the output side
// a stalled receiver holds the result register; the next final byte then waits
// in the input register and s_axis_tready drops until the result is taken
// reset (synchronous, active low) empties both registers and restarts the
// byte count, so the next byte is taken as the first byte of a new pdu
module tunnel_pdu_header_checker_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tpdu_pkg::BYTE_W-1:0]         s_axis_tdata,  // [7:0] pdu_byte
    input  logic                                s_axis_tlast,  // last_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] status, [4:1] action, [20:5] pay_len, [28:21] hdr_len,
    // [35:29] sub_hdr_cnt, [36] body_ok, [68:37] first_word, [71:69] zero
    output logic [tpdu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import tpdu_pkg::*;

    t_item   w_item;
    t_result w_res;
    t_result w_out_res;
    logic    w_advance;
    logic    w_out_free;
    logic    w_res_valid;

    // non-final bytes only update state, so they move on regardless of the output
    assign w_advance = w_item.valid && (!w_item.last || w_out_free);

    tpdu_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_data    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .o_ready   (s_axis_tready),
        .i_advance (w_advance),
        .o_item    (w_item)
    );

    tpdu_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    tpdu_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_free  (w_out_free),
        .o_res   (w_out_res)
    );

    assign m_axis_tdata = {3'b000, w_out_res};

endmodule

>>> verif/testbench.sv
module testbench;
    import tpdu_pkg::*;

    localparam int RUN_LIMIT    = 1_000_000;
    localparam int SETTLE_EDGES = 8;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata;   // [7:0] pdu_byte
    logic                   s_axis_tlast;   // last_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [0] status, [4:1] action, [20:5] pay_len, [28:21] hdr_len,
    // [35:29] sub_hdr_cnt, [36] body_ok, [68:37] first_word, [71:69] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    tunnel_pdu_header_checker_unit dut (.*);

    // parser state mirrored from the byte stream
    logic [IDX_W-1:0]  p_idx;
    logic [ACT_W-1:0]  p_act;
    logic              p_flags_nz;
    logic [PLEN_W-1:0] p_plen;
    logic [7:0]        p_hlen;
    logic [7:0]        p_sub_next;
    logic [CNT_W-1:0]  p_sub_cnt;
    logic              p_sub_err;
    logic [WORD_W-1:0] p_word0;
    logic              p_rsv_nz;
    logic              p_type_due;

    t_result     verdict_q[$];
    logic [7:0]  pdu_q[$];
    int          fails = 0;
    int          bytes_taken = 0;
    int          results_seen = 0;
    int          cycles = 0;

    // sender bursts
    bit          tx_gaps = 1'b0;
    int          tx_burst = 0;

    // receiver control, written by the tests at clock edges
    t_rx_mode    rx_mode;
    int          hold_len;
    int          hold_token;
    int          hold_seen = 0;
    int          hold_left = 0;
    logic [7:0]  rx_pat = 8'hb5;
    logic [5:0]  rx_tick = '0;

    task automatic parse_clear();
        p_idx      = '0;
        p_act      = '0;
        p_flags_nz = 1'b0;
        p_plen     = '0;
        p_hlen     = '0;
        p_sub_next = HDR_LEN;
        p_sub_cnt  = '0;
        p_sub_err  = 1'b0;
        p_word0    = '0;
        p_rsv_nz   = 1'b0;
        p_type_due = 1'b0;
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned i;
        int unsigned total;
        int unsigned off;
        logic        bad;
        t_result     r;
        i = 32'(p_idx);
        if (i == POS_ACTION) begin
            p_act      = b[ACT_W-1:0];
            p_flags_nz = |b[7:4];
        end else if (i == POS_PLEN_LO) begin
            p_plen[7:0] = b;
        end else if (i == POS_PLEN_HI) begin
            p_plen[15:8] = b;
        end else if (i == POS_HLEN) begin
            p_hlen = b;
        end else if (i < p_hlen) begin
            // subheader chain: length byte, then type byte, then filler
            if (!p_sub_err) begin
                if (p_type_due) begin
                    p_type_due = 1'b0;
                    if (b > SUB_TYPE_MAX)
                        p_sub_err = 1'b1;
                    else
                        p_sub_cnt = p_sub_cnt + 1'b1;
                end else if (i == p_sub_next) begin
                    if (b < SUB_LEN_MIN || b > p_hlen - i) begin
                        p_sub_err = 1'b1;
                    end else begin
                        p_sub_next = 8'(i + b);
                        p_type_due = 1'b1;
                    end
                end
            end
        end else if (p_hlen >= HDR_LEN) begin
            off = i - p_hlen;
            if (off < 4)
                p_word0 = p_word0 | (WORD_W'(b) << (8 * off));
            else if (off < 8 && b != 0)
                p_rsv_nz = 1'b1;
        end

        if (p_idx != IDX_MAX)
            p_idx = p_idx + 1'b1;

        if (last) begin
            total = i + 1;
            bad = total < HDR_LEN || p_act > ACT_DATA || p_flags_nz ||
                  p_hlen < HDR_LEN || p_hlen > total ||
                  p_plen != total - p_hlen || p_sub_err;
            r = '0;
            r.status      = bad;
            r.action      = p_act;
            r.pay_len     = p_plen;
            r.hdr_len     = p_hlen;
            r.sub_hdr_cnt = p_sub_cnt;
            if (!bad) begin
                if (p_act == ACT_CREATE_REQ)
                    r.body_ok = p_hlen == HDR_LEN && p_plen == REQ_BODY_LEN && !p_rsv_nz;
                else if (p_act == ACT_CREATE_RSP)
                    r.body_ok = p_hlen == HDR_LEN && p_plen == RSP_BODY_LEN;
                else
                    r.body_ok = 1'b1;
            end
            if (p_hlen >= HDR_LEN && total >= int'(p_hlen) + 4)
                r.first_word = p_word0;
            verdict_q.push_back(r);
            parse_clear();
        end
    endtask

    task automatic field_cmp(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fails++;
        end
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
        t_result got;
        t_result want;
        got = word[$bits(t_result)-1:0];
        if (verdict_q.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, word);
            fails++;
        end else begin
            want = verdict_q.pop_front();
            field_cmp("status", 32'(want.status), 32'(got.status));
            field_cmp("action", 32'(want.action), 32'(got.action));
            field_cmp("pay_len", 32'(want.pay_len), 32'(got.pay_len));
            field_cmp("hdr_len", 32'(want.hdr_len), 32'(got.hdr_len));
            field_cmp("sub_hdr_cnt", 32'(want.sub_hdr_cnt), 32'(got.sub_hdr_cnt));
            field_cmp("body_ok", 32'(want.body_ok), 32'(got.body_ok));
            field_cmp("first_word", want.first_word, got.first_word);
            field_cmp("pad", 32'd0, 32'(word[OUT_TDATA_W-1:$bits(t_result)]));
        end
    endtask

    // both channels are sampled here, before this edge's drives take effect
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            check_result(m_axis_tdata);
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            bytes_taken++;
            parse_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_tick == '0)
            rx_pat <= 8'($urandom_range(0, 255)) | 8'h01;
        else
            rx_pat <= {rx_pat[6:0], rx_pat[7]};
        if (hold_token != hold_seen) begin
            hold_seen     <= hold_token;
            hold_left     <= hold_len;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  m_axis_tready <= 1'b1;
                RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
                default:    m_axis_tready <= rx_pat[0];
            endcase
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_gaps && tx_burst == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            s_axis_tlast  <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            tx_burst = $urandom_range(1, 16);
        end
        if (tx_burst > 0)
            tx_burst--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_pdu();
        foreach (pdu_q[k])
            send_byte(pdu_q[k], k == pdu_q.size() - 1);
    endtask

    // the queue is read only after the byte sampler has run, so the last byte's verdict is already queued
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_phase(input t_rx_mode mode, input bit gaps);
        rx_mode <= mode;
        tx_gaps = gaps;
    endtask

    task automatic begin_pdu(input logic [7:0] act_byte);
        pdu_q.delete();
        pdu_q.push_back(act_byte);
        pdu_q.push_back(8'h00);
        pdu_q.push_back(8'h00);
        pdu_q.push_back(8'h00);
    endtask

    task automatic add_random(input int n);
        repeat (n) pdu_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_sub(input int len, input logic [7:0] kind);
        pdu_q.push_back(8'(len));
        pdu_q.push_back(kind);
        if (len > 2)
            add_random(len - 2);
    endtask

    task automatic seal_header();
        pdu_q[3] = 8'(pdu_q.size());
    endtask

    task automatic seal_plen();
        int n;
        n = pdu_q.size() - pdu_q[3];
        pdu_q[1] = n[7:0];
        pdu_q[2] = n[15:8];
    endtask

    task automatic add_request_body(input bit rsv_zero);
        add_random(4);
        if (rsv_zero)
            repeat (4) pdu_q.push_back(8'h00);
        else begin
            add_random(3);
            pdu_q.push_back(8'($urandom_range(1, 255)));
        end
        add_random(16);
    endtask

    task automatic mangle_pdu();
        int idx;
        idx = $urandom_range(0, pdu_q.size() - 1);
        case ($urandom_range(0, 3))
            0: pdu_q[idx] = 8'($urandom_range(0, 255));
            1: pdu_q[idx] = pdu_q[idx] ^ (8'h01 << $urandom_range(0, 7));
            2: while (pdu_q.size() > idx + 1) pdu_q.delete(pdu_q.size() - 1);
            default: add_random($urandom_range(1, 4));
        endcase
    endtask

    task automatic build_random_pdu();
        int         kind;
        logic [7:0] act;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            // line noise with no structure
            pdu_q.delete();
            add_random($urandom_range(1, 12));
        end else begin
            act = (kind < 22) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 2));
            begin_pdu(act);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4))
                    add_sub($urandom_range(2, 8), 8'($urandom_range(0, 1)));
            seal_header();
            case (act)
                ACT_CREATE_REQ: add_request_body($urandom_range(0, 4) != 0);
                ACT_CREATE_RSP: add_random(4);
                default: add_random(($urandom_range(0, 15) == 0) ? $urandom_range(41, 200)
                                                                 : $urandom_range(0, 40));
            endcase
            seal_plen();
            if ($urandom_range(0, 4) == 0)
                mangle_pdu();
        end
    endtask

    task automatic test_create_request();
        begin_pdu(8'(ACT_CREATE_REQ)); seal_header(); add_request_body(1'b1); seal_plen();
        send_pdu();
        begin_pdu(8'(ACT_CREATE_REQ)); seal_header(); add_request_body(1'b0); seal_plen();
        send_pdu();
        // well formed but the subheader makes the request body wrong
        begin_pdu(8'(ACT_CREATE_REQ)); add_sub(2, 8'h00); seal_header();
        add_request_body(1'b1); seal_plen();
        send_pdu();
        begin_pdu(8'(ACT_CREATE_REQ)); seal_header(); add_random(23); seal_plen();
        send_pdu();
    endtask

    task automatic test_create_response();
        begin_pdu(8'(ACT_CREATE_RSP)); seal_header();
        repeat (4) pdu_q.push_back(8'hff);
        seal_plen();
        send_pdu();
        begin_pdu(8'(ACT_CREATE_RSP)); seal_header(); add_random(8); seal_plen();
        send_pdu();
    endtask

    task automatic test_data();
        begin_pdu(8'(ACT_DATA)); add_sub(2, 8'h00); add_sub(5, 8'h01); seal_header();
        add_random(10); seal_plen();
        send_pdu();
        begin_pdu(8'(ACT_DATA)); seal_header(); seal_plen();
        send_pdu();
        // fewer than four payload bytes: first word reads as zero
        begin_pdu(8'(ACT_DATA)); seal_header(); add_random(3); seal_plen();
        send_pdu();
        begin_pdu(8'(ACT_DATA)); seal_header();
        repeat (6) pdu_q.push_back(8'h00);
        seal_plen();
        send_pdu();
    endtask

    task automatic test_header_faults();
        logic [7:0] bad_first[4] = '{8'h03, 8'h0f, 8'h12, 8'hf2};
        foreach (bad_first[k]) begin
            begin_pdu(bad_first[k]); seal_header(); add_random(5); seal_plen();
            send_pdu();
        end
        // pdus shorter than the fixed header
        pdu_q.delete(); pdu_q.push_back(8'h02);
        send_pdu();
        pdu_q.delete(); add_random(3);
        send_pdu();
        begin_pdu(8'(ACT_DATA)); seal_header(); add_random(6); seal_plen(); pdu_q[3] = 8'd3;
        send_pdu();
        begin_pdu(8'(ACT_DATA)); seal_header(); add_random(6); seal_plen(); pdu_q[3] = 8'd0;
        send_pdu();
        begin_pdu(8'(ACT_DATA)); seal_header(); add_random(6); seal_plen();
        pdu_q[3] = 8'd200;
        send_pdu();
        begin_pdu(8'(ACT_DATA)); seal_header(); add_random(6);
        pdu_q[1] = 8'hff; pdu_q[2] = 8'hff;
        send_pdu();
    endtask

    task automatic test_subheader_faults();
        logic [7:0] bad_len[2] = '{8'd0, 8'd1};
        logic [7:0] bad_kind[2] = '{8'd2, 8'hff};
        foreach (bad_len[k]) begin
            begin_pdu(8'(ACT_DATA)); pdu_q.push_back(bad_len[k]); add_random(5);
            seal_header(); add_random(4); seal_plen();
            send_pdu();
        end
        foreach (bad_kind[k]) begin
            begin_pdu(8'(ACT_DATA)); add_sub(3, bad_kind[k]); add_sub(2, 8'h00);
            seal_header(); add_random(4); seal_plen();
            send_pdu();
        end
        // length one past what is left of the header
        begin_pdu(8'(ACT_DATA)); pdu_q.push_back(8'd7); pdu_q.push_back(8'h00);
        add_random(4); seal_header(); add_random(4); seal_plen();
        send_pdu();
        // two good subheaders, then a broken one; the count stops at two
        begin_pdu(8'(ACT_DATA)); add_sub(2, 8'h01); add_sub(4, 8'h00);
        pdu_q.push_back(8'd1);
        add_sub(2, 8'h00); seal_header(); add_random(4); seal_plen();
        send_pdu();
        // largest header: one subheader that fills it exactly, then one too long
        begin_pdu(8'(ACT_DATA)); add_sub(251, 8'h01); seal_header(); add_random(4);
        seal_plen();
        send_pdu();
        begin_pdu(8'(ACT_DATA)); pdu_q.push_back(8'd252); pdu_q.push_back(8'h01);
        add_random(249); seal_header(); add_random(4); seal_plen();
        send_pdu();
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        set_phase(RX_ALWAYS, 1'b0);
        hold_len   <= 300;
        hold_token <= hold_token + 1;
        repeat (16) begin
            begin_pdu(8'(ACT_DATA)); seal_header(); add_random($urandom_range(0, 3));
            seal_plen();
            send_pdu();
        end
        wait_drained();
    endtask

    task automatic test_random();
        int start_bytes;
        int start_results;
        start_bytes   = bytes_taken;
        start_results = results_seen;
        set_phase(RX_RANDOM, 1'b1);
        while (bytes_taken - start_bytes < 200 || results_seen - start_results < 12) begin
            build_random_pdu();
            send_pdu();
            if ($urandom_range(0, 11) == 0)
                set_phase(t_rx_mode'($urandom_range(0, 2)), $urandom_range(0, 2) != 0);
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        rx_mode       <= RX_ALWAYS;
        hold_len      <= 0;
        hold_token    <= 0;
        parse_clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_phase(RX_RANDOM, 1'b1);
        test_create_request();
        test_create_response();
        test_data();
        set_phase(RX_PATTERN, 1'b1);
        test_header_faults();
        test_subheader_faults();
        wait_drained();
        test_backpressure();
        test_random();

        repeat (SETTLE_EDGES) @(posedge i_clk);
        if (fails == 0 && verdict_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tpdu_pkg.sv
rtl/tpdu_in_stage.sv
rtl/tpdu_parse.sv
rtl/tpdu_out_stage.sv
rtl/tunnel_pdu_header_checker_unit.sv
verif/testbench.sv
